[src/dual_via_sound_card_registers_core_assert.svh]
// Assertion macros shared by the dual interface chip register core.
`ifndef DUAL_VIA_SOUND_CARD_REGISTERS_CORE_ASSERT_SVH
`define DUAL_VIA_SOUND_CARD_REGISTERS_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define DVSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define DVSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/dvsc_pkg.sv]
// Package with types, constants and tables of the dual interface chip register core.
`timescale 1ns / 1ps
`default_nettype none
package dvsc_pkg;

  localparam int unsigned SOUND_REG_COUNT = 16;
  localparam int unsigned CHIP_COUNT      = 2;

  localparam logic [15:0] BASE_ADDR = 16'hC400;
  localparam logic [15:0] END_ADDR  = 16'hC490;

  localparam int unsigned MIRROR_DEPTH = 144;
  localparam int unsigned MIRROR_AW    = $clog2(MIRROR_DEPTH);

  localparam logic [3:0] OFF_ORB    = 4'h0;
  localparam logic [3:0] OFF_ORA    = 4'h1;
  localparam logic [3:0] OFF_T1CL   = 4'h4;
  localparam logic [3:0] OFF_T1CH   = 4'h5;
  localparam logic [3:0] OFF_T1LL   = 4'h6;
  localparam logic [3:0] OFF_T1LH   = 4'h7;
  localparam logic [3:0] OFF_T2CH   = 4'h9;
  localparam logic [3:0] OFF_IFR    = 4'hD;
  localparam logic [3:0] OFF_IER    = 4'hE;
  localparam logic [3:0] OFF_ORA_NH = 4'hF;

  localparam logic [7:0] PB_RESET  = 8'h00;
  localparam logic [7:0] PB_SELECT = 8'h07;
  localparam logic [7:0] PB_DATA   = 8'h06;

  localparam int unsigned FLAG_T1  = 6;
  localparam int unsigned FLAG_T2  = 5;
  localparam int unsigned FLAG_IRQ = 7;

  typedef enum logic [1:0] {
    PSG_NONE   = 2'd0,
    PSG_RESET  = 2'd1,
    PSG_SELECT = 2'd2,
    PSG_WRITE  = 2'd3
  } psg_cmd_e;

  typedef struct packed {
    logic [7:0] port_a;
    logic [7:0] flags;
    logic [7:0] enable;
    logic [7:0] ora_m;
    logic [7:0] t1c_lo;
    logic [7:0] t1c_hi;
    logic [7:0] t1l_lo;
    logic [7:0] t1l_hi;
    logic [7:0] ier_m;
    logic [1:0] armed;
  } chip_state_t;

  localparam chip_state_t CHIP_STATE_RESET = '{armed: 2'b01, default: 8'h00};

  typedef struct packed {
    logic       en;
    logic       write;
    logic       decoded;
    logic       chip;
    logic       in_region;
    logic [3:0] off;
    logic [7:0] data;
  } regs_req_t;

  typedef struct packed {
    psg_cmd_e   cmd;
    logic       channel;
    logic [7:0] value;
    logic       irq;
    logic [3:0] armed;
    logic       hit;
    logic [7:0] rd_byte;
  } regs_rsp_t;

  typedef logic [7:0] sel_table_t [256];

  function automatic sel_table_t build_sel_table();
    sel_table_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = 8'(i % SOUND_REG_COUNT);
    end
    return t;
  endfunction

  localparam sel_table_t SEL_TABLE = build_sel_table();

endpackage
`default_nettype wire

[src/dvsc_ram.sv]
// Generic single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module dvsc_ram #(
  parameter int unsigned Depth = 144,
  parameter int unsigned Width = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i && we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && !we_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[src/dvsc_mirror.sv]
// Register mirror: RAM plus per-entry valid bits that make unwritten bytes read as zero.
`timescale 1ns / 1ps
`default_nettype none
module dvsc_mirror import dvsc_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 we_i,
  input  wire logic [MIRROR_AW-1:0] addr_i,
  input  wire logic [7:0]           wdata_i,
  output logic      [7:0]           rdata_o
);

  logic [MIRROR_DEPTH-1:0] valid_q;
  logic                    rvalid_q;
  logic [7:0]              ram_rdata;

  dvsc_ram #(
    .Depth(MIRROR_DEPTH),
    .Width(8)
  ) u_ram (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .we_i   (we_i),
    .addr_i (addr_i),
    .wdata_i(wdata_i),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else if (en_i) begin
      if (we_i) begin
        valid_q[addr_i] <= 1'b1;
      end else begin
        rvalid_q <= valid_q[addr_i];
      end
    end
  end

  assign rdata_o = rvalid_q ? ram_rdata : 8'h00;

endmodule
`default_nettype wire

[src/dvsc_regs.sv]
// Per-chip register state: flag and enable rules, timer arming and sound commands.
`timescale 1ns / 1ps
`default_nettype none
module dvsc_regs import dvsc_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire regs_req_t req_i,
  output regs_rsp_t      rsp_o
);

  `include "dual_via_sound_card_registers_core_assert.svh"

  chip_state_t st_q [CHIP_COUNT];
  chip_state_t st_d [CHIP_COUNT];
  chip_state_t cur;
  chip_state_t nxt;
  psg_cmd_e    cmd;
  logic [7:0]  val;
  logic        hit;
  logic [7:0]  rd_byte;

  always_comb begin
    cur = st_q[req_i.chip];
    nxt = cur;
    cmd = PSG_NONE;
    val = 8'h00;

    if (req_i.in_region) begin
      case (req_i.off)
        OFF_ORA:  nxt.ora_m  = req_i.data;
        OFF_T1CL: nxt.t1c_lo = req_i.data;
        OFF_T1CH: nxt.t1c_hi = req_i.data;
        OFF_T1LL: nxt.t1l_lo = req_i.data;
        OFF_T1LH: nxt.t1l_hi = req_i.data;
        OFF_IER:  nxt.ier_m  = req_i.data;
        default: ;
      endcase
    end

    case (req_i.off)
      OFF_IFR: begin
        nxt.flags = nxt.flags & (~req_i.data | 8'h80);
        nxt.flags = {|(nxt.flags[6:0] & nxt.enable[6:0]), nxt.flags[6:0]};
      end
      OFF_IER: begin
        if (req_i.data[7]) begin
          nxt.enable = nxt.enable | {1'b0, req_i.data[6:0]};
          nxt.ier_m  = nxt.enable | 8'h80;
          nxt.flags  = {|(nxt.flags[6:0] & nxt.enable[6:0]), nxt.flags[6:0]};
          if (nxt.enable[FLAG_T1]) begin
            nxt.t1c_lo   = nxt.t1l_lo;
            nxt.t1c_hi   = nxt.t1l_hi;
            nxt.armed[0] = 1'b1;
          end
          if (nxt.enable[FLAG_T2]) begin
            nxt.armed[1] = 1'b1;
          end
        end else begin
          nxt.enable = nxt.enable & {1'b0, ~req_i.data[6:0]};
          nxt.ier_m  = nxt.enable | 8'h80;
          nxt.flags  = {|(nxt.flags[6:0] & nxt.enable[6:0]), nxt.flags[6:0]};
          if (!nxt.enable[FLAG_T2]) begin
            nxt.armed[1] = 1'b0;
          end
          if (!nxt.enable[FLAG_T1]) begin
            nxt.armed[0] = 1'b0;
          end
        end
      end
      OFF_T1CH: begin
        nxt.t1c_lo          = nxt.t1l_lo;
        nxt.t1l_hi          = req_i.data;
        nxt.flags[FLAG_T1]  = 1'b0;
        nxt.flags           = {|(nxt.flags[6:0] & nxt.enable[6:0]), nxt.flags[6:0]};
        if (nxt.enable[FLAG_T1]) begin
          nxt.t1c_lo   = nxt.t1l_lo;
          nxt.t1c_hi   = nxt.t1l_hi;
          nxt.armed[0] = 1'b1;
        end
      end
      OFF_T1LH: begin
        nxt.flags[FLAG_T1] = 1'b0;
        nxt.flags          = {|(nxt.flags[6:0] & nxt.enable[6:0]), nxt.flags[6:0]};
      end
      OFF_T2CH: begin
        nxt.flags[FLAG_T2] = 1'b0;
        nxt.flags          = {|(nxt.flags[6:0] & nxt.enable[6:0]), nxt.flags[6:0]};
        if (nxt.enable[FLAG_T2]) begin
          nxt.armed[1] = 1'b1;
        end
      end
      OFF_ORB: begin
        if (req_i.data == PB_RESET) begin
          cmd = PSG_RESET;
        end else if (req_i.data == PB_SELECT) begin
          cmd = PSG_SELECT;
          val = SEL_TABLE[cur.port_a];
        end else if (req_i.data == PB_DATA) begin
          cmd = PSG_WRITE;
          val = cur.port_a;
        end
      end
      OFF_ORA_NH: begin
        nxt.ora_m  = req_i.data;
        nxt.port_a = req_i.data;
      end
      OFF_ORA: begin
        nxt.port_a = req_i.data;
      end
      default: ;
    endcase
  end

  always_comb begin
    st_d = st_q;
    if (req_i.en && req_i.decoded && req_i.write) begin
      st_d[req_i.chip] = nxt;
    end
  end

  always_comb begin
    hit     = req_i.in_region;
    rd_byte = 8'h00;
    case (req_i.off)
      OFF_ORA:  rd_byte = cur.ora_m;
      OFF_T1CL: rd_byte = cur.t1c_lo;
      OFF_T1CH: rd_byte = cur.t1c_hi;
      OFF_T1LL: rd_byte = cur.t1l_lo;
      OFF_T1LH: rd_byte = cur.t1l_hi;
      OFF_IFR:  rd_byte = cur.flags;
      OFF_IER:  rd_byte = cur.ier_m;
      default:  hit     = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHIP_COUNT; i++) begin
        st_q[i] <= CHIP_STATE_RESET;
      end
    end else begin
      st_q <= st_d;
    end
  end

  always_comb begin
    rsp_o         = '0;
    rsp_o.cmd     = (req_i.decoded && req_i.write) ? cmd : PSG_NONE;
    rsp_o.channel = (req_i.decoded && req_i.write && cmd != PSG_NONE) ? req_i.chip : 1'b0;
    rsp_o.value   = (req_i.decoded && req_i.write) ? val : 8'h00;
    rsp_o.irq     = st_d[req_i.chip].flags[FLAG_IRQ];
    rsp_o.armed   = {st_d[1].armed, st_d[0].armed};
    rsp_o.hit     = hit;
    rsp_o.rd_byte = rd_byte;
  end

  `DVSC_ASSERT_IMP(a_irq_chip0, st_q[0].flags[FLAG_IRQ],
                   |(st_q[0].flags[6:0] & st_q[0].enable[6:0]),
                   "chip 0 summary flag set without an enabled flag")
  `DVSC_ASSERT_IMP(a_irq_chip1, st_q[1].flags[FLAG_IRQ],
                   |(st_q[1].flags[6:0] & st_q[1].enable[6:0]),
                   "chip 1 summary flag set without an enabled flag")
  `DVSC_ASSERT_IMP(a_t2_armed_chip0, st_q[0].armed[1],
                   st_q[0].enable[FLAG_T2],
                   "chip 0 timer 2 armed while its enable bit is clear")

endmodule
`default_nettype wire

[src/dual_via_sound_card_registers_core.sv]
// Top level of the dual interface chip register core.
// Latency: a request's result is valid the cycle after it is accepted.
// Throughput: one request per cycle unless stalled; the mirror RAM has one port.
// The output register takes a new request whenever it is empty or drained in the same cycle.
// Reset: mirror valid bits, flags, enables and latches clear, timer 1 armed bits set, no output.
// No clearing pass after reset: mirror bytes never written read as zero at once.
`timescale 1ns / 1ps
`default_nettype none
module dual_via_sound_card_registers_core import dvsc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        operation_i,
  input  wire logic [15:0] bus_address_i,
  input  wire logic [7:0]  write_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       read_data_o,
  output logic [1:0]       psg_command_o,
  output logic             psg_channel_o,
  output logic [7:0]       psg_value_o,
  output logic             irq_pending_o,
  output logic [3:0]       timer_armed_flags_o
);

  `include "dual_via_sound_card_registers_core_assert.svh"

  logic       acc;
  logic       decoded;
  regs_req_t  req;
  regs_rsp_t  rsp;
  logic [7:0] mem_rdata;

  logic       out_valid_q, out_valid_d;
  logic       use_mem_q;
  logic [7:0] byte_q;
  psg_cmd_e   cmd_q;
  logic       chan_q;
  logic [7:0] value_q;
  logic       irq_q;
  logic [3:0] armed_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign acc        = in_valid_i && !in_stall_o;
  assign decoded    = (bus_address_i >= BASE_ADDR) && (bus_address_i < END_ADDR);

  always_comb begin
    req           = '0;
    req.en        = acc;
    req.write     = operation_i;
    req.decoded   = decoded;
    req.chip      = bus_address_i[7];
    req.in_region = (bus_address_i[6:4] == 3'd0);
    req.off       = bus_address_i[3:0];
    req.data      = write_data_i;
  end

  dvsc_regs u_regs (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  dvsc_mirror u_mirror (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (acc && decoded),
    .we_i   (operation_i),
    .addr_i (bus_address_i[MIRROR_AW-1:0]),
    .wdata_i(write_data_i),
    .rdata_o(mem_rdata)
  );

  assign out_valid_d = acc || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      use_mem_q <= decoded && !operation_i && !rsp.hit;
      byte_q    <= (decoded && !operation_i && rsp.hit) ? rsp.rd_byte : 8'h00;
      cmd_q     <= rsp.cmd;
      chan_q    <= rsp.channel;
      value_q   <= rsp.value;
      irq_q     <= rsp.irq;
      armed_q   <= rsp.armed;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign read_data_o         = use_mem_q ? mem_rdata : byte_q;
  assign psg_command_o       = cmd_q;
  assign psg_channel_o       = chan_q;
  assign psg_value_o         = value_q;
  assign irq_pending_o       = irq_q;
  assign timer_armed_flags_o = armed_q;

  `DVSC_ASSERT_NXT(a_acc_gives_result, acc, out_valid_o,
                   "accepted request produced no result")
  `DVSC_ASSERT_IMP(a_none_is_quiet, out_valid_o && psg_command_o == PSG_NONE,
                   psg_value_o == 8'h00 && psg_channel_o == 1'b0,
                   "idle sound command carries a value or channel")
  `DVSC_ASSERT_IMP(a_select_in_range, out_valid_o && psg_command_o == PSG_SELECT,
                   32'(psg_value_o) < SOUND_REG_COUNT,
                   "register select beyond sound register count")

endmodule
`default_nettype wire
